[hw/rtl/bmms_pkg.sv]
// Shared types and codes of the block matching motion search.
package bmms_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] CMD_LOAD_CUR = 2'd0;
    localparam logic [1:0] CMD_LOAD_WIN = 2'd1;
    localparam logic [1:0] CMD_START    = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_BLOCK_SIZE    = 3'd0;
    localparam logic [2:0] REG_SEARCH_RANGE  = 3'd1;
    localparam logic [2:0] REG_SAD_TOLERANCE = 3'd2;
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd3;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd4;

    // Write strobes of the sample stores.
    typedef struct packed {
        logic cur_we;
        logic win_we;
    } store_wr_t;

    // Main search sequencer.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CAND   = 9'b000000010,
        ST_PIX_A  = 9'b000000100,
        ST_PIX_D  = 9'b000001000,
        ST_UPDATE = 9'b000010000,
        ST_NEXT   = 9'b000100000,
        ST_SNAP   = 9'b001000000,
        ST_CONF   = 9'b010000000,
        ST_FINISH = 9'b100000000
    } srch_state_t;

    // Confidence sequencer.
    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_LOAD = 4'b0010,
        C_MUL  = 4'b0100,
        C_DIV  = 4'b1000
    } conf_state_t;

    // Products formed by the shared serial multiplier, in issue order.
    typedef enum logic [2:0] {
        OP_TT  = 3'd0,
        OP_NP2 = 3'd1,
        OP_N   = 3'd2,
        OP_A   = 3'd3,
        OP_B   = 3'd4,
        OP_BB  = 3'd5,
        OP_P   = 3'd6,
        OP_Q   = 3'd7
    } conf_op_t;

endpackage

[hw/rtl/bmms_store.sv]
// Current block and reference window sample memories with registered reads.
module bmms_store #(
    parameter int SB        = 16,
    parameter int CUR_DEPTH = 256,
    parameter int WIN_DEPTH = 1024,
    parameter int CAW       = $clog2(CUR_DEPTH),
    parameter int WAW       = $clog2(WIN_DEPTH)
) (
    input  logic                clk,
    input  bmms_pkg::store_wr_t wr,
    input  logic [SB-1:0]       wdata,
    input  logic [CAW-1:0]      cur_waddr,
    input  logic [WAW-1:0]      win_waddr,
    input  logic [CAW-1:0]      cur_raddr,
    input  logic [WAW-1:0]      win_raddr,
    output logic [SB-1:0]       cur_rdata,
    output logic [SB-1:0]       win_rdata
);
    import bmms_pkg::*;

    logic [SB-1:0] cur_mem [CUR_DEPTH];
    logic [SB-1:0] win_mem [WIN_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.cur_we)
        begin
            cur_mem[cur_waddr] <= wdata;
        end
        cur_rdata <= cur_mem[cur_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.win_we)
        begin
            win_mem[win_waddr] <= wdata;
        end
        win_rdata <= win_mem[win_raddr];
    end

endmodule

[hw/rtl/bmms_conf.sv]
// Confidence unit: serial shift-add multiplier and restoring divider.
module bmms_conf #(
    parameter int SB   = 16,
    parameter int MB   = 16,
    parameter int NPW  = $clog2(((MB + 1) / 2) * ((MB + 1) / 2) + 1),
    parameter int SADW = SB + NPW,
    parameter int S1W  = SB + NPW,
    parameter int S2W  = 2 * SB + NPW
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [15:0]     tsad,
    input  logic [NPW-1:0]  npix,
    input  logic [SADW-1:0] best,
    input  logic [S1W-1:0]  s1,
    input  logic [S2W-1:0]  s2,
    output logic            done,
    output logic [15:0]     conf
);
    import bmms_pkg::*;

    localparam int NW   = 32 + 2 * NPW;
    localparam int AW   = NPW + S2W;
    localparam int V4W  = AW + 2;
    localparam int BBW  = 2 * SADW;
    localparam int F1W  = ((NW > BBW) ? NW : BBW) + 1;
    localparam int F2W  = ((V4W > NW) ? V4W : NW) + 1;
    localparam int MW   = (F1W > F2W) ? F1W : F2W;
    localparam int PW   = 2 * MW;
    localparam int CNTW = $clog2(MW + 1);

    conf_state_t     state_reg;
    conf_op_t        op_reg;
    logic [PW-1:0]   mcand_reg;
    logic [MW-1:0]   mplier_reg;
    logic [PW-1:0]   acc_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [15:0]     quo_reg;

    logic [31:0]      tt_reg;
    logic [2*NPW-1:0] np2_reg;
    logic [NW-1:0]    n_reg;
    logic [AW-1:0]    a_reg;
    logic [AW-1:0]    b_reg;
    logic [BBW-1:0]   bb_reg;
    logic [V4W-1:0]   v4_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    q_reg;

    logic [MW-1:0] opa;
    logic [MW-1:0] opb;
    logic [PW:0]   rem_dbl;
    logic [PW-1:0] prod_next;

    always_comb
    begin
        case (op_reg)
            OP_TT:
            begin
                opa = MW'(tsad);
                opb = MW'(tsad);
            end
            OP_NP2:
            begin
                opa = MW'(npix);
                opb = MW'(npix);
            end
            OP_N:
            begin
                opa = MW'(tt_reg);
                opb = MW'(np2_reg);
            end
            OP_A:
            begin
                opa = MW'(npix);
                opb = MW'(s2);
            end
            OP_B:
            begin
                opa = MW'(s1);
                opb = MW'(s1);
            end
            OP_BB:
            begin
                opa = MW'(best);
                opb = MW'(best);
            end
            OP_P:
            begin
                opa = MW'(n_reg);
                opb = MW'(v4_reg);
            end
            OP_Q:
            begin
                opa = MW'(n_reg) + MW'(bb_reg);
                opb = MW'(v4_reg) + MW'(n_reg);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
    assign rem_dbl   = {acc_reg, 1'b0};
    assign conf      = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            op_reg    <= OP_TT;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= OP_TT;
                        state_reg <= C_LOAD;
                    end
                end
                C_LOAD:
                begin
                    state_reg <= C_MUL;
                end
                C_MUL:
                begin
                    if (cnt_reg == CNTW'(MW - 1))
                    begin
                        case (op_reg)
                            OP_TT:   op_reg <= OP_NP2;
                            OP_NP2:  op_reg <= OP_N;
                            OP_N:    op_reg <= OP_A;
                            OP_A:    op_reg <= OP_B;
                            OP_B:    op_reg <= OP_BB;
                            OP_BB:   op_reg <= OP_P;
                            OP_P:    op_reg <= OP_Q;
                            default: op_reg <= OP_TT;
                        endcase
                        if (op_reg == OP_BB)
                        begin
                            // The variance term is checked before the wide products.
                            if (a_reg <= b_reg)
                            begin
                                done      <= 1'b1;
                                state_reg <= C_IDLE;
                            end
                            else
                            begin
                                state_reg <= C_LOAD;
                            end
                        end
                        else if (op_reg == OP_Q)
                        begin
                            state_reg <= C_DIV;
                        end
                        else
                        begin
                            state_reg <= C_LOAD;
                        end
                    end
                end
                C_DIV:
                begin
                    if (cnt_reg == CNTW'(15))
                    begin
                        done      <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                quo_reg <= '0;
            end
            C_LOAD:
            begin
                mcand_reg  <= PW'(opa);
                mplier_reg <= opb;
                acc_reg    <= '0;
                cnt_reg    <= '0;
            end
            C_MUL:
            begin
                acc_reg    <= prod_next;
                mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[MW-1:1]};
                cnt_reg    <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(MW - 1))
                begin
                    cnt_reg <= '0;
                    case (op_reg)
                        OP_TT:  tt_reg  <= 32'(prod_next);
                        OP_NP2: np2_reg <= (2*NPW)'(prod_next);
                        OP_N:   n_reg   <= NW'(prod_next);
                        OP_A:   a_reg   <= AW'(prod_next);
                        OP_B:   b_reg   <= AW'(prod_next);
                        OP_BB:
                        begin
                            bb_reg <= BBW'(prod_next);
                            v4_reg <= {a_reg - b_reg, 2'b00};
                        end
                        OP_P:
                        begin
                            p_reg <= prod_next;
                        end
                        default:
                        begin
                            // The remainder starts at p, which is below q.
                            q_reg   <= prod_next;
                            acc_reg <= p_reg;
                        end
                    endcase
                end
            end
            C_DIV:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (rem_dbl >= {1'b0, q_reg})
                begin
                    acc_reg <= PW'(rem_dbl - {1'b0, q_reg});
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    acc_reg <= PW'(rem_dbl);
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule

[hw/rtl/block_match_motion_search.sv]
// Load beats are accepted back to back while idle; a start first sums the sampled block
// pixels, then visits each candidate and accumulates its SAD when it lies in the frame,
// then runs the serial confidence unit, whose operand width MW is 49 at the default
// parameters. The single SAD datapath and the bit-serial multiplier set the search time.
// The block is not ready during a search. Reset (rst_n, asynchronous) clears the
// sequencer, write pointers and output valid and loads the register defaults.
module block_match_motion_search #(
    parameter int MAX_BLOCK   = 16,
    parameter int MAX_SEARCH  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample[15:0], block_x[28:16], block_y[41:29], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // motion_x[4:0], motion_y[9:5], best_sad[31:10],
                                   // confidence[47:32]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bmms_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int CUR_DEPTH = MAX_BLOCK * MAX_BLOCK;
    localparam int WIN_SIDE  = MAX_BLOCK + 2 * MAX_SEARCH;
    localparam int WIN_DEPTH = WIN_SIDE * WIN_SIDE;
    localparam int CAW       = $clog2(CUR_DEPTH);
    localparam int WAW       = $clog2(WIN_DEPTH);
    localparam int BSW       = $clog2(MAX_BLOCK + 1);
    localparam int SRW       = $clog2(MAX_SEARCH + 1);
    localparam int SDW       = $clog2(WIN_SIDE + 1);
    localparam int UW        = $clog2(2 * MAX_SEARCH + 1);
    localparam int IW        = $clog2(MAX_BLOCK + 2);
    localparam int NPW       = $clog2(((MAX_BLOCK + 1) / 2) * ((MAX_BLOCK + 1) / 2) + 1);
    localparam int SADW      = SB + NPW;
    localparam int S1W       = SB + NPW;
    localparam int S2W       = 2 * SB + NPW;
    localparam int LW        = SADW + NPW + 20;

    // Configuration registers.
    logic [4:0]  bsize_reg;
    logic [3:0]  srange_reg;
    logic [15:0] tsad_reg;
    logic [13:0] fw_reg;
    logic [13:0] fh_reg;

    // Sequencer and per-search registers.
    srch_state_t     state_reg;
    logic [CAW-1:0]  cur_ptr_reg;
    logic [WAW-1:0]  win_ptr_reg;
    logic [12:0]     x0_reg;
    logic [12:0]     y0_reg;
    logic [BSW-1:0]  bs_reg;
    logic [SRW-1:0]  sr_reg;
    logic [SDW-1:0]  side_reg;
    logic [15:0]     t_reg;
    logic [BSW-1:0]  bw_reg;
    logic [BSW-1:0]  bh_reg;
    logic [NPW-1:0]  npix_reg;
    logic [IW-1:0]   i_reg;
    logic [IW-1:0]   j_reg;
    logic [UW-1:0]   u_reg;
    logic [UW-1:0]   v_reg;
    logic            sum_pass_reg;
    logic            found_reg;
    logic [SADW-1:0] sad_reg;
    logic [SADW-1:0] sad0_reg;
    logic [SADW-1:0] best_reg;
    logic [UW-1:0]   bu_reg;
    logic [UW-1:0]   bv_reg;
    logic [S1W-1:0]  s1_reg;
    logic [S2W-1:0]  s2_reg;
    logic [15:0]     conf_res_reg;

    // Input beat fields.
    logic [1:0]    in_cmd;
    logic [SB-1:0] in_sample;
    logic [12:0]   in_x;
    logic [12:0]   in_y;
    logic          in_fire;

    assign in_cmd    = s_tuser;
    assign in_sample = s_tdata[SB-1:0];
    assign in_x      = s_tdata[28:16];
    assign in_y      = s_tdata[41:29];
    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Job parameters worked out from the registers when a start beat arrives.
    logic [BSW-1:0] bs_c;
    logic [SRW-1:0] sr_c;
    logic [13:0]    wrem_c;
    logic [13:0]    hrem_c;
    logic [BSW-1:0] bw_c;
    logic [BSW-1:0] bh_c;
    logic [BSW:0]   bw1_c;
    logic [BSW:0]   bh1_c;
    logic           outside_c;

    always_comb
    begin
        if (bsize_reg < 5'd2)
        begin
            bs_c = BSW'(2);
        end
        else if (int'(bsize_reg) > MAX_BLOCK)
        begin
            bs_c = BSW'(MAX_BLOCK);
        end
        else
        begin
            bs_c = BSW'(bsize_reg);
        end
        if (int'(srange_reg) > MAX_SEARCH)
        begin
            sr_c = SRW'(MAX_SEARCH);
        end
        else
        begin
            sr_c = SRW'(srange_reg);
        end
        outside_c = ({1'b0, in_x} >= fw_reg) || ({1'b0, in_y} >= fh_reg);
        wrem_c    = fw_reg - {1'b0, in_x};
        hrem_c    = fh_reg - {1'b0, in_y};
        bw_c      = (wrem_c < 14'(bs_c)) ? BSW'(wrem_c) : bs_c;
        bh_c      = (hrem_c < 14'(bs_c)) ? BSW'(hrem_c) : bs_c;
        bw1_c     = (BSW+1)'(bw_c) + (BSW+1)'(1);
        bh1_c     = (BSW+1)'(bh_c) + (BSW+1)'(1);
    end

    // Store addressing: the current block has row stride bs and the window row
    // stride side; the candidate (u, v) offsets the window read.
    store_wr_t       st_wr;
    logic [CAW-1:0]  cur_raddr;
    logic [WAW-1:0]  win_raddr;
    logic [SB-1:0]   cur_rdata;
    logic [SB-1:0]   win_rdata;

    assign st_wr.cur_we = in_fire && (in_cmd == CMD_LOAD_CUR);
    assign st_wr.win_we = in_fire && (in_cmd == CMD_LOAD_WIN);
    assign cur_raddr    = CAW'(j_reg * bs_reg + i_reg);
    assign win_raddr    = WAW'((v_reg + j_reg) * side_reg + (u_reg + i_reg));

    bmms_store #(
        .SB        (SB),
        .CUR_DEPTH (CUR_DEPTH),
        .WIN_DEPTH (WIN_DEPTH)
    ) u_store (
        .clk       (clk),
        .wr        (st_wr),
        .wdata     (in_sample),
        .cur_waddr (cur_ptr_reg),
        .win_waddr (win_ptr_reg),
        .cur_raddr (cur_raddr),
        .win_raddr (win_raddr),
        .cur_rdata (cur_rdata),
        .win_rdata (win_rdata)
    );

    // Per-pixel arithmetic.
    logic [SB-1:0]   absdiff;
    logic [2*SB-1:0] sq;
    logic [IW-1:0]   i_step;
    logic [IW-1:0]   j_step;

    assign absdiff = (cur_rdata > win_rdata) ? cur_rdata - win_rdata : win_rdata - cur_rdata;
    assign sq      = (2*SB)'(cur_rdata) * (2*SB)'(cur_rdata);
    assign i_step  = i_reg + IW'(2);
    assign j_step  = j_reg + IW'(2);

    // A candidate is searched only when its displaced block stays in the frame.
    logic [14:0] cx;
    logic [14:0] cy;
    logic        in_frame;
    logic [UW-1:0] sr_u;
    logic [UW-1:0] sr2_u;

    assign sr_u     = UW'(sr_reg);
    assign sr2_u    = sr_u + sr_u;
    assign cx       = 15'(x0_reg) + 15'(u_reg);
    assign cy       = 15'(y0_reg) + 15'(v_reg);
    assign in_frame = (cx >= 15'(sr_reg)) && (cy >= 15'(sr_reg))
                   && (cx + 15'(bw_reg) <= 15'(fw_reg) + 15'(sr_reg))
                   && (cy + 15'(bh_reg) <= 15'(fh_reg) + 15'(sr_reg));

    // L1 norms of the candidate and of the best vector so far.
    logic [UW:0] mn;
    logic [UW:0] bn;
    logic        take;

    assign mn = (UW+1)'((u_reg >= sr_u) ? u_reg - sr_u : sr_u - u_reg)
              + (UW+1)'((v_reg >= sr_u) ? v_reg - sr_u : sr_u - v_reg);
    assign bn = (UW+1)'((bu_reg >= sr_u) ? bu_reg - sr_u : sr_u - bu_reg)
              + (UW+1)'((bv_reg >= sr_u) ? bv_reg - sr_u : sr_u - bv_reg);
    assign take = !found_reg || (sad_reg < best_reg) || ((sad_reg == best_reg) && (mn < bn));

    // A nonzero winner must beat the zero vector by more than 0.10*tsad per pixel.
    logic snap;

    assign snap = ((bu_reg != sr_u) || (bv_reg != sr_u))
               && (LW'(sad0_reg - best_reg) * LW'(10) <= LW'(t_reg) * LW'(npix_reg));

    // Confidence unit.
    logic        conf_done;
    logic [15:0] conf_val;

    bmms_conf #(
        .SB (SB),
        .MB (MAX_BLOCK)
    ) u_conf (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_SNAP),
        .tsad  (t_reg),
        .npix  (npix_reg),
        .best  (best_reg),
        .s1    (s1_reg),
        .s2    (s2_reg),
        .done  (conf_done),
        .conf  (conf_val)
    );

    // Result fields.
    logic signed [UW:0] dx_s;
    logic signed [UW:0] dy_s;

    assign dx_s = $signed((UW+1)'(bu_reg)) - $signed((UW+1)'(sr_reg));
    assign dy_s = $signed((UW+1)'(bv_reg)) - $signed((UW+1)'(sr_reg));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg  <= 5'd8;
            srange_reg <= 4'd4;
            tsad_reg   <= 16'd1024;
            fw_reg     <= 14'd1920;
            fh_reg     <= 14'd1080;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE:    bsize_reg  <= cfg_data[4:0];
                REG_SEARCH_RANGE:  srange_reg <= cfg_data[3:0];
                REG_SAD_TOLERANCE: tsad_reg   <= cfg_data;
                REG_FRAME_WIDTH:   fw_reg     <= cfg_data[13:0];
                REG_FRAME_HEIGHT:  fh_reg     <= cfg_data[13:0];
                default:           ;
            endcase
        end
    end

    // Control: sequencer, write pointers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_ptr_reg <= '0;
            win_ptr_reg <= '0;
            m_tvalid    <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (in_cmd)
                            CMD_LOAD_CUR:
                            begin
                                cur_ptr_reg <= (cur_ptr_reg == CAW'(CUR_DEPTH - 1))
                                             ? '0 : cur_ptr_reg + 1'b1;
                            end
                            CMD_LOAD_WIN:
                            begin
                                win_ptr_reg <= (win_ptr_reg == WAW'(WIN_DEPTH - 1))
                                             ? '0 : win_ptr_reg + 1'b1;
                            end
                            CMD_START:
                            begin
                                cur_ptr_reg <= '0;
                                win_ptr_reg <= '0;
                                state_reg   <= outside_c ? ST_FINISH : ST_PIX_A;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CAND:
                begin
                    state_reg <= in_frame ? ST_PIX_A : ST_NEXT;
                end
                ST_PIX_A:
                begin
                    state_reg <= ST_PIX_D;
                end
                ST_PIX_D:
                begin
                    if ((i_step >= IW'(bw_reg)) && (j_step >= IW'(bh_reg)))
                    begin
                        state_reg <= sum_pass_reg ? ST_CAND : ST_UPDATE;
                    end
                    else
                    begin
                        state_reg <= ST_PIX_A;
                    end
                end
                ST_UPDATE:
                begin
                    state_reg <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if ((u_reg == sr2_u) && (v_reg == sr2_u))
                    begin
                        state_reg <= ST_SNAP;
                    end
                    else
                    begin
                        state_reg <= ST_CAND;
                    end
                end
                ST_SNAP:
                begin
                    state_reg <= ST_CONF;
                end
                ST_CONF:
                begin
                    if (conf_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // The result waits here only while the previous one is still held.
                    if (!m_tvalid || m_tready)
                    begin
                        m_tvalid  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_cmd == CMD_START))
                begin
                    x0_reg       <= in_x;
                    y0_reg       <= in_y;
                    bs_reg       <= bs_c;
                    sr_reg       <= sr_c;
                    side_reg     <= SDW'(bs_c) + SDW'(sr_c) + SDW'(sr_c);
                    t_reg        <= (tsad_reg == 16'd0) ? 16'd1 : tsad_reg;
                    bw_reg       <= bw_c;
                    bh_reg       <= bh_c;
                    npix_reg     <= NPW'(bw1_c[BSW:1] * bh1_c[BSW:1]);
                    i_reg        <= '0;
                    j_reg        <= '0;
                    u_reg        <= '0;
                    v_reg        <= '0;
                    sum_pass_reg <= 1'b1;
                    found_reg    <= 1'b0;
                    s1_reg       <= '0;
                    s2_reg       <= '0;
                    // A block outside the frame reports the zero vector with no score.
                    bu_reg       <= UW'(sr_c);
                    bv_reg       <= UW'(sr_c);
                    best_reg     <= '0;
                    conf_res_reg <= '0;
                end
            end
            ST_CAND:
            begin
                sad_reg <= '0;
                i_reg   <= '0;
                j_reg   <= '0;
            end
            ST_PIX_D:
            begin
                if (sum_pass_reg)
                begin
                    s1_reg <= s1_reg + S1W'(cur_rdata);
                    s2_reg <= s2_reg + S2W'(sq);
                end
                else
                begin
                    sad_reg <= sad_reg + SADW'(absdiff);
                end
                if (i_step >= IW'(bw_reg))
                begin
                    i_reg <= '0;
                    j_reg <= j_step;
                    if (j_step >= IW'(bh_reg))
                    begin
                        sum_pass_reg <= 1'b0;
                    end
                end
                else
                begin
                    i_reg <= i_step;
                end
            end
            ST_UPDATE:
            begin
                if ((u_reg == sr_u) && (v_reg == sr_u))
                begin
                    sad0_reg <= sad_reg;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                    best_reg  <= sad_reg;
                    bu_reg    <= u_reg;
                    bv_reg    <= v_reg;
                end
            end
            ST_NEXT:
            begin
                if (u_reg == sr2_u)
                begin
                    u_reg <= '0;
                    v_reg <= v_reg + 1'b1;
                end
                else
                begin
                    u_reg <= u_reg + 1'b1;
                end
            end
            ST_SNAP:
            begin
                if (snap)
                begin
                    bu_reg   <= sr_u;
                    bv_reg   <= sr_u;
                    best_reg <= sad0_reg;
                end
            end
            ST_CONF:
            begin
                if (conf_done)
                begin
                    conf_res_reg <= conf_val;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid || m_tready)
                begin
                    m_tdata <= {conf_res_reg, 22'(best_reg), 5'(dy_s), 5'(dx_s)};
                end
            end
            default:
            begin
                sad_reg <= sad_reg;
            end
        endcase
    end

endmodule
